FILE: rtl/lu_pkg.sv
// lu_pkg: shared types and constants for the LU linear solver.
// No dependencies.
package lu_pkg;
    localparam int MAX_ORDER = 64;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 64;
    localparam int ORDER_W   = 7;

    localparam logic [1:0] ACT_WR_MAT = 2'd0;
    localparam logic [1:0] ACT_WR_RHS = 2'd1;
    localparam logic [1:0] ACT_SOLVE  = 2'd2;

    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_PIV_RD, S_PIV_W, S_L_RD, S_L_W, S_DIV, S_L_WR,
        S_U_RD, S_U_W, S_U_MUL, S_U_WR,
        S_F_INIT, S_F_INIT_W, S_F_RD, S_F_W, S_F_MUL, S_F_WR,
        S_B_INIT, S_B_INIT_W, S_B_RD, S_B_W, S_B_MUL, S_B_DRD, S_B_DW, S_B_DIV,
        S_OUT_RD, S_OUT_W, S_OUT
    } t_state;

    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat_sgn(input logic [63:0] m, input logic neg,
                                            input logic over);
        logic [63:0] lim;
        logic [63:0] mm;
        lim = neg ? SIGN_BIT : POS_MAX;
        mm  = (over || m > lim) ? lim : m;
        sat_sgn = neg ? (64'd0 - mm) : mm;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (((a[63] ^ b[63]) != 1'b0) && ((a[63] ^ r[63]) != 1'b0))
            sat_sub = a[63] ? SIGN_BIT : POS_MAX;
        else
            sat_sub = r;
    endfunction
endpackage

FILE: rtl/lu_ram.sv
// lu_ram: generic single-port RAM with registered read.
// No dependencies.
module lu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/lu_arith.sv
// lu_arith: shared Q32.32 multiplier (four 32x32 partial products over
// several cycles) and restoring divider (one quotient bit a cycle).
// Depends on lu_pkg.
module lu_arith (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mul_go,
    input  logic        i_div_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);
    import lu_pkg::*;

    logic        r_busy, n_busy;
    logic        r_is_div, n_is_div;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [63:0] r_ma, n_ma;
    logic [63:0] r_mb, n_mb;
    logic [127:0] r_acc, n_acc;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_q, n_q;
    logic        r_over, n_over;
    logic        r_done, n_done;
    logic [63:0] r_res, n_res;
    logic [63:0] pp;
    logic [64:0] rs;
    logic        bit_in;

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_is_div <= n_is_div; r_cnt <= n_cnt; r_neg <= n_neg;
        r_ma <= n_ma; r_mb <= n_mb; r_acc <= n_acc; r_rem <= n_rem;
        r_q <= n_q; r_over <= n_over; r_res <= n_res;
    end

    always_comb begin
        n_busy = r_busy; n_is_div = r_is_div; n_cnt = r_cnt; n_neg = r_neg;
        n_ma = r_ma; n_mb = r_mb; n_acc = r_acc; n_rem = r_rem; n_q = r_q;
        n_over = r_over; n_done = 1'b0; n_res = r_res;
        pp = '0; rs = '0; bit_in = 1'b0;
        if (i_mul_go || i_div_go) begin
            n_busy = 1'b1; n_is_div = i_div_go; n_cnt = '0;
            n_neg = i_a[63] ^ i_b[63];
            n_ma = mag(i_a); n_mb = mag(i_b);
            n_acc = '0; n_rem = '0; n_q = '0; n_over = 1'b0;
        end else if (r_busy) begin
            if (!r_is_div) begin
                // one 32x32 partial product per cycle
                case (r_cnt[1:0])
                    2'd0: pp = r_ma[31:0]  * r_mb[31:0];
                    2'd1: pp = r_ma[63:32] * r_mb[31:0];
                    2'd2: pp = r_ma[31:0]  * r_mb[63:32];
                    default: pp = r_ma[63:32] * r_mb[63:32];
                endcase
                case (r_cnt[1:0])
                    2'd0: n_acc = r_acc + {64'd0, pp};
                    2'd1, 2'd2: n_acc = r_acc + {32'd0, pp, 32'd0};
                    default: n_acc = r_acc + {pp, 64'd0};
                endcase
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd4) begin
                    n_busy = 1'b0; n_done = 1'b1;
                    n_res = sat_sgn(r_acc[95:32], r_neg, r_acc[127:96] != 32'd0);
                    n_cnt = r_cnt;
                    n_acc = r_acc;
                end
            end else begin
                if (r_cnt == 7'd96) begin
                    n_busy = 1'b0; n_done = 1'b1;
                    n_res = sat_sgn(r_q, r_neg, r_over);
                end else begin
                    bit_in = (r_cnt < 7'd64) ? r_ma[6'(7'd63 - r_cnt)] : 1'b0;
                    rs = {r_rem[63:0], bit_in};
                    if (rs >= {1'b0, r_mb}) begin
                        n_rem = rs - {1'b0, r_mb};
                        n_q = {r_q[62:0], 1'b1};
                    end else begin
                        n_rem = rs;
                        n_q = {r_q[62:0], 1'b0};
                    end
                    if (r_q[63]) n_over = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                end
            end
        end
    end
endmodule

FILE: rtl/lu_linear_solver_top.sv
// lu_linear_solver_top: Q32.32 dense solver, LU (Doolittle, no pivoting).
// Depends on lu_pkg, lu_ram, lu_arith.
//
// channel | direction | signals
// in      | request   | i_in_valid/o_in_ready, action,row,col,value_in
// out     | result    | o_out_valid/i_out_ready, index,value_out,singular,last
// cfg     | write     | i_cfg_valid/o_cfg_ready, i_cfg_data (matrix_size)
//
// Load requests are written to memory as they are accepted. A solve walks the
// matrix memory with one shared multiply and a bit-serial divider.
// Results stream once the output register is free, one per cycle if singular;
// otherwise each result waits for its read of the x memory. Reset is
// synchronous active low; memories are not cleared. No request is taken from
// the solve request until the last result has been loaded into the output
// register.
module lu_linear_solver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic signed [63:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_index,
    output logic signed [63:0] o_value_out,
    output logic        o_singular,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import lu_pkg::*;

    t_state r_state, n_state;
    logic [6:0]  r_size;
    logic [6:0]  r_n, n_n;
    logic [5:0]  r_k, n_k, r_j, n_j, r_i, n_i;
    logic [63:0] r_piv, n_piv, r_l, n_l, r_acc, n_acc, r_t, n_t;
    logic        r_sing, n_sing;
    logic        r_ov, n_ov;
    logic [5:0]  r_oidx, n_oidx;
    logic [63:0] r_oval, n_oval;
    logic        r_olast, n_olast, r_osing, n_osing;

    // matrix memory
    logic        m_we;
    logic [11:0] m_addr;
    logic [63:0] m_wd, m_rd;
    // rhs, c, x memories
    logic        b_we, c_we, x_we;
    logic [5:0]  b_addr, c_addr, x_addr;
    logic [63:0] b_wd, c_wd, x_wd, b_rd, c_rd, x_rd;

    logic        mul_go, div_go, ar_done;
    logic [63:0] ar_a, ar_b, ar_res;
    logic        in_acc;

    lu_ram #(.WIDTH(64), .DEPTH(4096)) u_mat (.i_clk, .i_we(m_we), .i_addr(m_addr),
        .i_wdata(m_wd), .o_rdata(m_rd));
    lu_ram #(.WIDTH(64), .DEPTH(64)) u_rhs (.i_clk, .i_we(b_we), .i_addr(b_addr),
        .i_wdata(b_wd), .o_rdata(b_rd));
    lu_ram #(.WIDTH(64), .DEPTH(64)) u_cv (.i_clk, .i_we(c_we), .i_addr(c_addr),
        .i_wdata(c_wd), .o_rdata(c_rd));
    lu_ram #(.WIDTH(64), .DEPTH(64)) u_xv (.i_clk, .i_we(x_we), .i_addr(x_addr),
        .i_wdata(x_wd), .o_rdata(x_rd));

    lu_arith u_ar (.i_clk, .i_rst_n, .i_mul_go(mul_go), .i_div_go(div_go),
        .i_a(ar_a), .i_b(ar_b), .o_done(ar_done), .o_res(ar_res));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_index     = r_oidx;
    assign o_value_out = r_oval;
    assign o_singular  = r_osing;
    assign o_last      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= 7'd64;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_valid) r_size <= i_cfg_data;
        end
        r_n <= n_n; r_k <= n_k; r_j <= n_j; r_i <= n_i;
        r_piv <= n_piv; r_l <= n_l; r_acc <= n_acc; r_t <= n_t; r_sing <= n_sing;
        r_oidx <= n_oidx; r_oval <= n_oval; r_olast <= n_olast; r_osing <= n_osing;
    end
    assign o_out_valid = r_ov;

    function automatic logic [11:0] ad(input logic [5:0] r, input logic [5:0] c);
        ad = {r, c};
    endfunction

    always_comb begin
        n_state = r_state; n_n = r_n; n_k = r_k; n_j = r_j; n_i = r_i;
        n_piv = r_piv; n_l = r_l; n_acc = r_acc; n_t = r_t; n_sing = r_sing;
        n_oidx = r_oidx; n_oval = r_oval; n_olast = r_olast; n_osing = r_osing;
        n_ov = r_ov && !i_out_ready;
        m_we = 1'b0; m_addr = '0; m_wd = r_acc;
        b_we = 1'b0; b_addr = '0; b_wd = i_value_in;
        c_we = 1'b0; c_addr = '0; c_wd = r_acc;
        x_we = 1'b0; x_addr = '0; x_wd = ar_res;
        mul_go = 1'b0; div_go = 1'b0; ar_a = r_l; ar_b = r_piv;
        case (r_state)
            S_IDLE: begin
                m_addr = ad(i_row, i_col); m_wd = i_value_in;
                b_addr = i_row;
                if (in_acc) begin
                    case (i_action)
                        ACT_WR_MAT: m_we = 1'b1;
                        ACT_WR_RHS: b_we = 1'b1;
                        ACT_SOLVE: begin
                            n_n = (r_size == 7'd0) ? 7'd1 :
                                  (r_size > 7'd64) ? 7'd64 : r_size;
                            n_k = '0; n_sing = 1'b0;
                            n_state = S_PIV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // ---- factorization ----
            S_PIV_RD: begin m_addr = ad(r_k, r_k); n_state = S_PIV_W; end
            S_PIV_W: begin
                n_piv = m_rd;
                if (m_rd == 64'd0) begin
                    n_sing = 1'b1; n_k = '0; n_state = S_OUT;
                end else if ({1'b0, r_k} + 7'd1 >= r_n) begin
                    n_k = '0; n_state = S_F_INIT;
                end else begin
                    n_j = r_k + 6'd1; n_state = S_L_RD;
                end
            end
            S_L_RD: begin m_addr = ad(r_j, r_k); n_state = S_L_W; end
            S_L_W: begin
                div_go = 1'b1; ar_a = m_rd; ar_b = r_piv; n_state = S_DIV;
            end
            S_DIV: if (ar_done) begin
                n_l = ar_res; n_state = S_L_WR;
            end
            S_L_WR: begin
                m_we = 1'b1; m_addr = ad(r_j, r_k); m_wd = r_l;
                n_i = r_k + 6'd1; n_state = S_U_RD;
            end
            S_U_RD: begin m_addr = ad(r_k, r_i); n_state = S_U_W; end
            S_U_W: begin
                mul_go = 1'b1; ar_a = m_rd; ar_b = r_l;
                n_state = S_U_MUL;
            end
            S_U_MUL: begin
                m_addr = ad(r_j, r_i);
                if (ar_done) begin n_t = ar_res; n_state = S_U_WR; end
            end
            S_U_WR: begin
                // read of A[j][i] was issued in the previous cycle
                m_we = 1'b1; m_addr = ad(r_j, r_i); m_wd = sat_sub(m_rd, r_t);
                if ({1'b0, r_i} + 7'd1 < r_n) begin
                    n_i = r_i + 6'd1; n_state = S_U_RD;
                end else if ({1'b0, r_j} + 7'd1 < r_n) begin
                    n_j = r_j + 6'd1; n_state = S_L_RD;
                end else begin
                    n_k = r_k + 6'd1; n_state = S_PIV_RD;
                end
            end
            // ---- forward substitution ----
            S_F_INIT: begin b_addr = r_k; n_state = S_F_INIT_W; end
            S_F_INIT_W: begin
                n_acc = b_rd; n_j = '0;
                n_state = (r_k == 6'd0) ? S_F_WR : S_F_RD;
            end
            S_F_RD: begin m_addr = ad(r_k, r_j); c_addr = r_j; n_state = S_F_W; end
            S_F_W: begin
                mul_go = 1'b1; ar_a = m_rd; ar_b = c_rd; n_state = S_F_MUL;
            end
            S_F_MUL: if (ar_done) begin
                n_acc = sat_sub(r_acc, ar_res);
                if (r_j + 6'd1 < r_k) begin
                    n_j = r_j + 6'd1; n_state = S_F_RD;
                end else n_state = S_F_WR;
            end
            S_F_WR: begin
                c_we = 1'b1; c_addr = r_k; c_wd = r_acc;
                if ({1'b0, r_k} + 7'd1 < r_n) begin
                    n_k = r_k + 6'd1; n_state = S_F_INIT;
                end else begin
                    n_k = 6'(r_n - 7'd1); n_state = S_B_INIT;
                end
            end
            // ---- back substitution ----
            S_B_INIT: begin c_addr = r_k; n_state = S_B_INIT_W; end
            S_B_INIT_W: begin
                n_acc = c_rd; n_j = r_k + 6'd1;
                n_state = ({1'b0, r_k} + 7'd1 < r_n) ? S_B_RD : S_B_DRD;
            end
            S_B_RD: begin m_addr = ad(r_k, r_j); x_addr = r_j; n_state = S_B_W; end
            S_B_W: begin
                mul_go = 1'b1; ar_a = m_rd; ar_b = x_rd; n_state = S_B_MUL;
            end
            S_B_MUL: if (ar_done) begin
                n_acc = sat_sub(r_acc, ar_res);
                if ({1'b0, r_j} + 7'd1 < r_n) begin
                    n_j = r_j + 6'd1; n_state = S_B_RD;
                end else n_state = S_B_DRD;
            end
            S_B_DRD: begin m_addr = ad(r_k, r_k); n_state = S_B_DW; end
            S_B_DW: begin
                div_go = 1'b1; ar_a = r_acc; ar_b = m_rd; n_state = S_B_DIV;
            end
            S_B_DIV: if (ar_done) begin
                x_we = 1'b1; x_addr = r_k; x_wd = ar_res;
                if (r_k == 6'd0) n_state = S_OUT_RD;
                else begin n_k = r_k - 6'd1; n_state = S_B_INIT; end
            end
            // ---- result streaming ----
            S_OUT_RD: begin x_addr = r_k; n_state = S_OUT_W; end
            S_OUT_W: begin x_addr = r_k; n_state = S_OUT; end
            S_OUT: begin
                x_addr = r_k;
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1; n_oidx = r_k;
                    n_oval = r_sing ? 64'd0 : x_rd;
                    n_osing = r_sing;
                    n_olast = ({1'b0, r_k} + 7'd1 == r_n);
                    if ({1'b0, r_k} + 7'd1 == r_n) n_state = S_IDLE;
                    else begin
                        n_k = r_k + 6'd1;
                        x_addr = r_k + 6'd1;
                        n_state = r_sing ? S_OUT : S_OUT_W;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_index))
        else $error("result dropped under stall");
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_value_out == 64'd0)
        else $error("singular result not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready)
        else $error("request taken during solve");
endmodule

FILE: tb/lu_solver_checker.sv
// lu_solver_checker: watches the request, result and register channels of the
// LU solver, predicts each solution stream and compares it. Depends on lu_pkg.
`timescale 1ns / 1ps

module lu_solver_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic [63:0]        i_value_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [5:0]         i_index,
    input  logic [63:0]        i_value_out,
    input  logic               i_singular,
    input  logic               i_last,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    import lu_pkg::*;

    typedef struct packed {
        logic [5:0]  index;
        logic [63:0] value;
        logic        singular;
        logic        last;
    } t_solution;

    logic [63:0] mat_copy [MAX_ORDER*MAX_ORDER];
    logic [63:0] rhs_copy [MAX_ORDER];
    logic [63:0] fwd_copy [MAX_ORDER];
    logic [63:0] sol_copy [MAX_ORDER];
    logic [6:0]  order_reg;
    t_solution   solution_q [$];
    int          errors = 0;

    assign o_errors  = errors;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] clamp_mag(input logic [127:0] m, input logic neg);
        logic [127:0] lim;
        lim = neg ? {64'd0, SIGN_BIT} : {64'd0, POS_MAX};
        if (m > lim) m = lim;
        return neg ? (64'd0 - m[63:0]) : m[63:0];
    endfunction

    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        return clamp_mag(p >> 32, a[63] ^ b[63]);
    endfunction

    function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] num;
        logic [127:0] den;
        num = {32'd0, abs64(a), 32'd0};
        den = {64'd0, abs64(b)};
        return clamp_mag(num / den, a[63] ^ b[63]);
    endfunction

    function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) return d[64] ? SIGN_BIT : POS_MAX;
        return d[63:0];
    endfunction

    // Factor in place, then forward and back substitution; 0 on zero pivot.
    function automatic bit factor_and_solve(input int n);
        logic [63:0] piv, lf, acc;
        for (int k = 0; k < n; k++) begin
            piv = mat_copy[k*MAX_ORDER+k];
            if (piv == 64'd0) return 1'b0;
            for (int j = k + 1; j < n; j++) begin
                lf = q_div(mat_copy[j*MAX_ORDER+k], piv);
                mat_copy[j*MAX_ORDER+k] = lf;
                for (int i = k + 1; i < n; i++)
                    mat_copy[j*MAX_ORDER+i] = q_sub(mat_copy[j*MAX_ORDER+i],
                                                    q_mul(mat_copy[k*MAX_ORDER+i], lf));
            end
        end
        for (int k = 0; k < n; k++) begin
            acc = rhs_copy[k];
            for (int j = 0; j < k; j++)
                acc = q_sub(acc, q_mul(mat_copy[k*MAX_ORDER+j], fwd_copy[j]));
            fwd_copy[k] = acc;
        end
        for (int k = n - 1; k >= 0; k--) begin
            acc = fwd_copy[k];
            for (int j = k + 1; j < n; j++)
                acc = q_sub(acc, q_mul(mat_copy[k*MAX_ORDER+j], sol_copy[j]));
            sol_copy[k] = q_div(acc, mat_copy[k*MAX_ORDER+k]);
        end
        return 1'b1;
    endfunction

    task automatic predict_solve();
        int        n;
        bit        ok;
        t_solution s;
        n = (order_reg < 1) ? 1 : ((order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg));
        ok = factor_and_solve(n);
        if (!ok)
            for (int k = 0; k < MAX_ORDER; k++) sol_copy[k] = 64'd0;
        for (int k = 0; k < n; k++) begin
            s.index    = k[5:0];
            s.value    = ok ? sol_copy[k] : 64'd0;
            s.singular = !ok;
            s.last     = (k == n - 1);
            solution_q.push_back(s);
        end
    endtask

    always @(posedge i_clk) begin
        t_solution s;
        if (!i_rst_n) begin
            order_reg = 7'd64;
        end else begin
            if (i_cfg_valid && i_cfg_ready) order_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                case (i_action)
                    ACT_WR_MAT: mat_copy[i_row*MAX_ORDER+i_col] = i_value_in;
                    ACT_WR_RHS: rhs_copy[i_row] = i_value_in;
                    ACT_SOLVE:  predict_solve();
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (solution_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result index=%0d value=%h singular=%b last=%b",
                             $time, i_index, i_value_out, i_singular, i_last);
                end else begin
                    s = solution_q.pop_front();
                    if (s.index !== i_index) begin
                        errors++;
                        $display("%0t: index expected %0d actual %0d", $time, s.index, i_index);
                    end
                    if (s.value !== i_value_out) begin
                        errors++;
                        $display("%0t: value_out[%0d] expected %h actual %h",
                                 $time, s.index, s.value, i_value_out);
                    end
                    if (s.singular !== i_singular) begin
                        errors++;
                        $display("%0t: singular[%0d] expected %b actual %b",
                                 $time, s.index, s.singular, i_singular);
                    end
                    if (s.last !== i_last) begin
                        errors++;
                        $display("%0t: last[%0d] expected %b actual %b",
                                 $time, s.index, s.last, i_last);
                    end
                end
            end
        end
        o_pending = solution_q.size();
    end

endmodule

FILE: tb/tb_lu_linear_solver_top.sv
// tb_lu_linear_solver_top: stimulus and verdict for the LU linear solver.
// Depends on lu_pkg, lu_linear_solver_top and lu_solver_checker.
`timescale 1ns / 1ps

module tb_lu_linear_solver_top;
    import lu_pkg::*;

    // Action code the block has no use for; it must be swallowed silently.
    localparam logic [1:0] ACT_NOP = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [5:0]  i_row;
    logic [5:0]  i_col;
    logic signed [63:0] i_value_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_index;
    logic signed [63:0] o_value_out;
    logic        o_singular;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;

    int errors;
    int pending;
    int requests_sent;
    bit calm;            // no idling on either side
    int hold_requests;   // long receiver stalls asked for
    int holds_done;      // long receiver stalls carried out

    lu_linear_solver_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_row(i_row), .i_col(i_col), .i_value_in(i_value_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_index(o_index), .o_value_out(o_value_out),
        .o_singular(o_singular), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    lu_solver_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_action(i_action), .i_row(i_row), .i_col(i_col), .i_value_in(i_value_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_index(o_index), .i_value_out(o_value_out),
        .i_singular(o_singular), .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Hard stop in case the run hangs; the largest solve here is of order ten.
    initial begin
        #20_000_000;
        $display("** lu_linear_solver_top: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin
        i_out_ready = 1'b0;
        holds_done  = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_done < hold_requests) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                holds_done++;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Offer one request; hold it until accepted. Drop valid only across a gap.
    task automatic send(input logic [1:0] act, input int r, input int c,
                        input logic [63:0] v);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_row      <= r[5:0];
        i_col      <= c[5:0];
        i_value_in <= v;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // Drain: every result back, then a few cycles for a load still in flight.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [6:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Roughly +-8.0 in Q32.32.
    function automatic logic [63:0] rand_small();
        logic signed [63:0] v;
        v = $signed(rand64()) >>> 28;
        return v;
    endfunction

    // Load a full order-n system; mostly diagonally dominant, sometimes raw bits.
    task automatic load_system(input int n, input bit wild);
        logic [63:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (wild) v = rand64();
                else if (r == c) v = (64'(8 * n + 1) << 32) + (rand64() >> 34);
                else v = rand_small();
                send(ACT_WR_MAT, r, c, v);
            end
            send(ACT_WR_RHS, r, 0, wild ? rand64() : rand_small());
        end
    endtask

    int n, k, seqs;

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_action    = ACT_WR_MAT;
        i_row       = '0;
        i_col       = '0;
        i_value_in  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 7'd1;
        calm        = 1'b0;
        hold_requests = 0;
        requests_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: order 0 is taken as 1; extremes of value.
        write_order(7'd0);
        send(ACT_WR_MAT, 0, 0, POS_MAX);
        send(ACT_WR_RHS, 0, 0, SIGN_BIT);
        send(ACT_SOLVE, 0, 0, 64'd0);
        send(ACT_NOP, 63, 63, 64'hFFFF_FFFF_FFFF_FFFF);
        // Repeated solve on the already factored matrix.
        send(ACT_SOLVE, 63, 63, 64'd0);
        // Zero pivot.
        send(ACT_WR_MAT, 0, 0, 64'd0);
        send(ACT_SOLVE, 0, 0, 64'd0);
        // Order 2: ill-scaled entries drive the divide and multiply into saturation.
        write_order(7'd2);
        send(ACT_WR_MAT, 0, 0, 64'd1);
        send(ACT_WR_MAT, 0, 1, POS_MAX);
        send(ACT_WR_MAT, 1, 0, SIGN_BIT);
        send(ACT_WR_MAT, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
        send(ACT_WR_RHS, 0, 0, POS_MAX);
        send(ACT_WR_RHS, 1, 0, 64'h0000_0001_0000_0000);
        // Stall the receiver long while loads keep coming behind the solve.
        hold_requests++;
        send(ACT_SOLVE, 0, 0, 64'd0);
        send(ACT_WR_MAT, 63, 63, 64'd0);
        send(ACT_WR_RHS, 63, 0, POS_MAX);
        // Zero pivot found at the second diagonal.
        send(ACT_WR_MAT, 0, 0, 64'h0000_0001_0000_0000);
        send(ACT_WR_MAT, 0, 1, 64'h0000_0001_0000_0000);
        send(ACT_WR_MAT, 1, 0, 64'h0000_0001_0000_0000);
        send(ACT_WR_MAT, 1, 1, 64'h0000_0001_0000_0000);
        send(ACT_SOLVE, 0, 0, 64'd0);

        // Random systems, small orders mostly.
        seqs = 0;
        while (requests_sent < 410 || seqs < 12) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0) begin
                // Sender pauses until the block is drained, then goes on.
                wait_idle();
            end
            write_order(7'(n));
            load_system(n, $urandom_range(0, 3) == 0);
            // Noise: unused action and out-of-order rewrites.
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 2))
                    0: send(ACT_NOP, $urandom_range(0, 63), $urandom_range(0, 63), rand64());
                    1: send(ACT_WR_MAT, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                            rand_small());
                    default: send(ACT_WR_RHS, $urandom_range(0, n - 1), 0, rand64());
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, n - 1);
                send(ACT_WR_MAT, k, k, 64'd0);
            end
            send(ACT_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), rand64());
            if ($urandom_range(0, 4) == 0) send(ACT_SOLVE, 0, 0, 64'd0);
            seqs++;
        end

        // Tail without idling.
        wait_idle();
        calm = 1'b1;
        repeat (3) begin
            n = $urandom_range(1, 5);
            write_order(7'(n));
            load_system(n, 1'b0);
            send(ACT_SOLVE, 0, 0, 64'd0);
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("** lu_linear_solver_top: PASSED **");
        else
            $display("** lu_linear_solver_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lu_pkg.sv
rtl/lu_ram.sv
rtl/lu_arith.sv
rtl/lu_linear_solver_top.sv
tb/lu_solver_checker.sv
tb/tb_lu_linear_solver_top.sv
